@@ rtl/core/ptdt_pkg.sv @@
// Shared types and constants of the periodic task due table.
// Used by the interfaces, the slot cell, the top level and the checker; depends on nothing.
package ptdt_pkg;

   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 8;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int TASK_W   = 6;

   // Command codes carried by a request word.
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SERVICE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SET_TIME = 3'd5;

   // Status codes carried by a response word.
   localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_IDX = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RUN     = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NONE    = 2'd3;

   // A service command reports at most this many slots.
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS);

   // Control broadcast from the sequencer to every slot cell.
   typedef struct packed {
      logic              adv;        // shift the walk token one cell on
      logic              kill;       // drop the walk token wherever it is
      logic              tick_en;    // a tick walk is in progress
      logic              svc_clr;    // clear pending in the cell holding the token
      logic              wr_en;      // add or restart writes the addressed slot
      logic              pause_en;   // pause clears in-use of the addressed slot
      logic              clr_pend;   // add also clears pending of the addressed slot
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] cur_time;
   } ptdt_ctl_type;

endpackage

@@ rtl/core/ptdt_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on ptdt_pkg for the field widths.
interface ptdt_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptdt_pkg::CMD_W-1:0]    cmd;
   logic [ptdt_pkg::SLOT_W-1:0]   slot;
   logic [ptdt_pkg::TIME_W-1:0]   start_time;
   logic [ptdt_pkg::TIME_W-1:0]   period;
   logic [ptdt_pkg::TIME_W-1:0]   new_time;

   modport source (output valid, cmd, slot, start_time, period, new_time, input ready);
   modport sink   (input valid, cmd, slot, start_time, period, new_time, output ready);
endinterface

interface ptdt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ptdt_pkg::STATUS_W-1:0]   status;
   logic [ptdt_pkg::TASK_W-1:0]     task_index;
   logic                            last;
   logic [ptdt_pkg::TIME_W-1:0]     uptime;

   modport source (output valid, status, task_index, last, uptime, input ready);
   modport sink   (input valid, status, task_index, last, uptime, output ready);
endinterface

@@ rtl/core/ptdt_cell.sv @@
// One task slot of the due table: planned time, period, in-use and pending bits.
// Passes the walk token to its right-hand neighbour; depends on ptdt_pkg.
module ptdt_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptdt_pkg::ptdt_ctl_type ctl,
   input  logic                   tok_prev,
   output logic                   tok_out,
   output logic                   pend_out
);

   logic                          tok_ff, tok_in;
   logic                          in_use_ff, in_use_in;
   logic                          pend_ff, pend_in;
   logic [ptdt_pkg::TIME_W-1:0]   planned_ff, planned_in;
   logic [ptdt_pkg::TIME_W-1:0]   period_ff, period_in;
   logic                          sel, hit;

   always_comb begin
      sel = (ctl.slot == ptdt_pkg::SLOT_W'(INDEX));
      // A tick fires this slot when it is in use and its planned time has passed.
      hit = tok_ff && ctl.tick_en && in_use_ff && (planned_ff < ctl.cur_time);

      tok_in     = ctl.kill ? 1'b0 : (ctl.adv ? tok_prev : tok_ff);
      planned_in = planned_ff;
      period_in  = period_ff;
      in_use_in  = in_use_ff;
      pend_in    = pend_ff;

      if (ctl.wr_en && sel) begin
         planned_in = ctl.start_time;
         period_in  = ctl.period;
         in_use_in  = 1'b1;
         if (ctl.clr_pend) begin
            pend_in = 1'b0;
         end
      end else if (hit) begin
         planned_in = planned_ff + period_ff;
         pend_in    = 1'b1;
      end
      if (ctl.pause_en && sel) begin
         in_use_in = 1'b0;
      end
      if (tok_ff && ctl.svc_clr) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= 1'b0;
         in_use_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         tok_ff    <= tok_in;
         in_use_ff <= in_use_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      planned_ff <= planned_in;
      period_ff  <= period_in;
   end

   assign tok_out  = tok_ff;
   assign pend_out = pend_ff;

endmodule

@@ rtl/core/periodic_task_due_table.sv @@
// Top level of the periodic task due table: sequencer, time counters and response register.
// Depends on ptdt_pkg, ptdt_req_if, ptdt_rsp_if and ptdt_cell.
//
//   channel   port      direction   word contents
//   request   req_bus   in (sink)   cmd, slot, start_time, period, new_time
//   response  rsp_bus   out (src)   status, task_index, last, uptime
//
// Add, pause, restart, set time and unknown commands take effect in the cycle
// the request word is accepted; their single response is loaded from the reply
// state once the response register is free. A tick walks a token along the row
// of slot cells, one cell a cycle, and then loads its response from the reply
// state. A service with pending slots walks the same token, which waits at a
// pending slot while a response is held up; with nothing pending it answers
// through the reply state.
// Reset is synchronous and clears every in-use and pending bit and both counters.
// A stalled response holds the service walk and the reply state, not the tick walk;
// the request side stays closed until the current request word has produced its last response.
module periodic_task_due_table #(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ptdt_req_if.sink   req_bus,
   ptdt_rsp_if.source rsp_bus
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_TICK  = 2'd1;
   localparam logic [1:0] ST_SVC   = 2'd2;
   localparam logic [1:0] ST_REPLY = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [ptdt_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ptdt_pkg::STATUS_W-1:0]    reply_ff, reply_in;
   logic [ptdt_pkg::TIME_W-1:0]      cur_ff, cur_in;
   logic [ptdt_pkg::TIME_W-1:0]      up_ff, up_in;

   // Response register: it parts the walk from a stalled consumer.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ptdt_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ptdt_pkg::TASK_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [ptdt_pkg::TIME_W-1:0]      rsp_up_ff, rsp_up_in;

   ptdt_pkg::ptdt_ctl_type           ctl;
   logic [SLOTS:0]                   tok;
   logic                             tok_head;
   logic [SLOTS-1:0]                 pend_vec;
   logic [SLOTS-1:0]                 others;
   logic                             accept, out_free, load, slot_bad, fin;

   // The row of slot cells; the token enters at cell 0 and leaves past the last cell.
   assign tok[0] = tok_head;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      ptdt_cell #(
         .INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .tok_prev (tok[g]),
         .tok_out  (tok[g+1]),
         .pend_out (pend_vec[g])
      );
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign slot_bad      = (req_bus.slot >= ptdt_pkg::SLOT_W'(SLOTS));

   // Pending slots other than the one under the token. Slots below it are
   // already cleared, so this is empty exactly when the current hit is the final one.
   assign others = pend_vec & ~(SLOTS'(1) << idx_ff);
   assign fin    = (others == '0) || (cnt_ff == ptdt_pkg::CNT_W'(ptdt_pkg::MAX_RESULTS - 1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      reply_in = reply_ff;
      cur_in   = cur_ff;
      up_in    = up_ff;
      tok_head = 1'b0;
      load     = 1'b0;

      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_up_in     = rsp_up_ff;

      ctl            = '0;
      ctl.slot       = req_bus.slot;
      ctl.start_time = req_bus.start_time;
      ctl.period     = req_bus.period;
      ctl.cur_time   = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               reply_in = ptdt_pkg::STS_DONE;
               state_in = ST_REPLY;
               unique case (req_bus.cmd)
                  ptdt_pkg::CMD_TICK: begin
                     tok_head = 1'b1;
                     ctl.adv  = 1'b1;
                     idx_in   = '0;
                     state_in = ST_TICK;
                  end
                  ptdt_pkg::CMD_ADD, ptdt_pkg::CMD_RESTART: begin
                     if (slot_bad) begin
                        reply_in = ptdt_pkg::STS_BAD_IDX;
                     end else begin
                        ctl.wr_en    = 1'b1;
                        ctl.clr_pend = (req_bus.cmd == ptdt_pkg::CMD_ADD);
                     end
                  end
                  ptdt_pkg::CMD_PAUSE: begin
                     if (slot_bad) begin
                        reply_in = ptdt_pkg::STS_BAD_IDX;
                     end else begin
                        ctl.pause_en = 1'b1;
                     end
                  end
                  ptdt_pkg::CMD_SERVICE: begin
                     if (pend_vec == '0) begin
                        reply_in = ptdt_pkg::STS_NONE;
                     end else begin
                        tok_head = 1'b1;
                        ctl.adv  = 1'b1;
                        idx_in   = '0;
                        cnt_in   = '0;
                        state_in = ST_SVC;
                     end
                  end
                  ptdt_pkg::CMD_SET_TIME: begin
                     cur_in = req_bus.new_time;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            // Each cell compares and advances its own slot while it holds the token.
            ctl.tick_en = 1'b1;
            ctl.adv     = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (tok[SLOTS]) begin
               cur_in   = cur_ff + 1'b1;
               up_in    = up_ff + 1'b1;
               reply_in = ptdt_pkg::STS_DONE;
               state_in = ST_REPLY;
            end
         end
         ST_SVC: begin
            if (pend_vec[idx_ff]) begin
               if (out_free) begin
                  load          = 1'b1;
                  rsp_status_in = ptdt_pkg::STS_RUN;
                  rsp_index_in  = ptdt_pkg::TASK_W'(idx_ff);
                  rsp_last_in   = fin;
                  rsp_up_in     = up_ff;
                  ctl.svc_clr   = 1'b1;
                  cnt_in        = cnt_ff + 1'b1;
                  if (fin) begin
                     ctl.kill = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     ctl.adv = 1'b1;
                     idx_in  = idx_ff + 1'b1;
                  end
               end
            end else begin
               ctl.adv = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = reply_ff;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_up_in     = up_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         up_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         up_ff        <= up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      reply_ff      <= reply_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_up_ff     <= rsp_up_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.task_index = rsp_index_ff;
   assign rsp_bus.last       = rsp_last_ff;
   assign rsp_bus.uptime     = rsp_up_ff;

endmodule

@@ rtl/core/ptdt_checker.sv @@
// Port-level checks on the periodic task due table, and the bind that attaches them.
// Depends on ptdt_pkg and on the top level's channel ports.
module ptdt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ptdt_pkg::STATUS_W-1:0]   rsp_status,
   input logic [ptdt_pkg::TASK_W-1:0]     rsp_task_index,
   input logic                            rsp_last
);

   // Once a request word is taken the block is busy until its work is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in progress");

   // While a word that is not the final one of a service is on offer, the block is busy.
   a_busy_mid_service: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request side opened before the service finished");

   // Only a run-task word may be followed by more words of the same request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ptdt_pkg::STS_RUN) |-> rsp_last)
      else $error("non run-task response without last");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ptdt_pkg::STS_RUN) |-> (rsp_task_index == '0))
      else $error("task index set on a non run-task response");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind periodic_task_due_table ptdt_checker u_ptdt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_task_index (rsp_bus.task_index),
   .rsp_last       (rsp_bus.last)
);

@@ tb/sv/periodic_task_due_table_test.sv @@
// Self-checking test of the periodic task due table: directed words, then random traffic.
// Depends on ptdt_pkg, the ptdt_req_if and ptdt_rsp_if interfaces and periodic_task_due_table.
module periodic_task_due_table_test;

   localparam int SLOTS = 16;

   // The two command codes that the block treats as no-ops.
   localparam logic [ptdt_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [ptdt_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   // One response word as the block should present it.
   typedef struct packed {
      logic [ptdt_pkg::STATUS_W-1:0] status;
      logic [ptdt_pkg::TASK_W-1:0]   task_index;
      logic                          last;
      logic [ptdt_pkg::TIME_W-1:0]   uptime;
   } due_word_type;

   logic clock = 1'b0;
   logic reset;

   ptdt_req_if req_bus ();
   ptdt_rsp_if rsp_bus ();

   periodic_task_due_table #(
      .SLOTS (SLOTS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Our own copy of the task table. The planned times and periods are only
   // ever read for slots in use, and every way of putting a slot in use
   // writes both, so their start-up contents never matter.
   logic [ptdt_pkg::TIME_W-1:0] due_at     [SLOTS];
   logic [ptdt_pkg::TIME_W-1:0] repeat_gap [SLOTS];
   bit                          slot_live  [SLOTS];
   bit                          slot_owed  [SLOTS];
   logic [ptdt_pkg::TIME_W-1:0] now_secs;
   logic [ptdt_pkg::TIME_W-1:0] uptime_secs;

   // Response words that the block still owes us, oldest first.
   due_word_type owed_words[$];

   // Idling switches for the two sides; each phase of the test sets them.
   bit req_idle;
   bit rsp_idle;

   int mismatches;
   int words_sent;
   int words_checked;
   int runs_reported;

   // Applies one accepted request word to the table copy and queues the
   // response words that it must cause.
   function automatic void advance_table(input logic [ptdt_pkg::CMD_W-1:0]  cmd,
                                         input logic [ptdt_pkg::SLOT_W-1:0] slot,
                                         input logic [ptdt_pkg::TIME_W-1:0] start_time,
                                         input logic [ptdt_pkg::TIME_W-1:0] period,
                                         input logic [ptdt_pkg::TIME_W-1:0] new_time);
      due_word_type word;
      int           due_count;
      int           emitted;
      word = '{status: ptdt_pkg::STS_DONE, task_index: '0, last: 1'b1, uptime: '0};
      case (cmd)
         ptdt_pkg::CMD_TICK: begin
            // The comparison is against the time before this tick counts up,
            // and the planned time wraps round like the counters do.
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i] && due_at[i] < now_secs) begin
                  slot_owed[i] = 1'b1;
                  due_at[i]    = due_at[i] + repeat_gap[i];
               end
            end
            now_secs    = now_secs + 1;
            uptime_secs = uptime_secs + 1;
         end
         ptdt_pkg::CMD_ADD, ptdt_pkg::CMD_PAUSE, ptdt_pkg::CMD_RESTART: begin
            if (slot >= SLOTS) begin
               word.status = ptdt_pkg::STS_BAD_IDX;
            end else if (cmd == ptdt_pkg::CMD_PAUSE) begin
               // A pause leaves any pending bit alone.
               slot_live[slot] = 1'b0;
            end else begin
               due_at[slot]     = start_time;
               repeat_gap[slot] = period;
               slot_live[slot]  = 1'b1;
               if (cmd == ptdt_pkg::CMD_ADD) begin
                  slot_owed[slot] = 1'b0;
               end
            end
         end
         ptdt_pkg::CMD_SERVICE: begin
            due_count = 0;
            foreach (slot_owed[i]) begin
               if (slot_owed[i]) begin
                  due_count++;
               end
            end
            if (due_count > ptdt_pkg::MAX_RESULTS) begin
               due_count = ptdt_pkg::MAX_RESULTS;
            end
            if (due_count == 0) begin
               word.status = ptdt_pkg::STS_NONE;
            end else begin
               // Lowest slot first; anything beyond the limit waits for the
               // next service.
               emitted = 0;
               for (int i = 0; i < SLOTS && emitted < due_count; i++) begin
                  if (slot_owed[i]) begin
                     slot_owed[i] = 1'b0;
                     owed_words.push_back('{status: ptdt_pkg::STS_RUN,
                                            task_index: ptdt_pkg::TASK_W'(i),
                                            last: (emitted == due_count - 1),
                                            uptime: uptime_secs});
                     emitted++;
                  end
               end
               return;
            end
         end
         ptdt_pkg::CMD_SET_TIME: begin
            now_secs = new_time;
         end
         default: begin
         end
      endcase
      word.uptime = uptime_secs;
      owed_words.push_back(word);
   endfunction

   // Offers one request word, after a random gap if req_idle is set, and waits
   // for the block to take it. Valid is left high on acceptance so that a
   // following word with no gap goes out on the very next edge.
   task automatic send_word(input logic [ptdt_pkg::CMD_W-1:0]  cmd,
                            input logic [ptdt_pkg::SLOT_W-1:0] slot,
                            input logic [ptdt_pkg::TIME_W-1:0] start_time,
                            input logic [ptdt_pkg::TIME_W-1:0] period,
                            input logic [ptdt_pkg::TIME_W-1:0] new_time);
      int gap;
      gap = req_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.slot       <= slot;
      req_bus.start_time <= start_time;
      req_bus.period     <= period;
      req_bus.new_time   <= new_time;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      advance_table(cmd, slot, start_time, period, new_time);
      words_sent++;
   endtask

   // An empty table: service finds nothing and a spare code does nothing.
   task automatic test_idle_table();
      send_word(ptdt_pkg::CMD_SERVICE, 8'hFF, '1, '1, '1);
      send_word(CMD_SPARE_7, 8'h00, '0, '0, '0);
   endtask

   // Slot indices beyond the table are refused by every table command.
   task automatic test_bad_slot();
      send_word(ptdt_pkg::CMD_ADD, 8'(SLOTS), 32'h0000_0000, 32'h0000_0001, '0);
      send_word(ptdt_pkg::CMD_PAUSE, 8'hFF, '0, '0, '0);
      send_word(ptdt_pkg::CMD_RESTART, 8'h80, '1, '1, '0);
   endtask

   // Fills every slot, makes all of them due on a tick that wraps the clock,
   // then checks that pause and restart keep a pending bit while add drops it.
   task automatic test_full_table();
      for (int i = 0; i < SLOTS; i++) begin
         if (i == SLOTS - 1) begin
            // Planned time plus period wraps past the top of the range.
            send_word(ptdt_pkg::CMD_ADD, 8'(i), 32'hFFFF_FFF0, 32'hFFFF_FFFF, '0);
         end else begin
            send_word(ptdt_pkg::CMD_ADD, 8'(i), 32'h0000_0000, 32'(i * 3), '0);
         end
      end
      send_word(ptdt_pkg::CMD_SET_TIME, 8'h00, '0, '0, 32'hFFFF_FFFF);
      send_word(ptdt_pkg::CMD_TICK, 8'h00, '0, '0, '0);
      send_word(ptdt_pkg::CMD_PAUSE, 8'd2, '0, '0, '0);
      send_word(ptdt_pkg::CMD_RESTART, 8'd6, 32'h0000_0005, 32'h0000_0002, '0);
      send_word(ptdt_pkg::CMD_ADD, 8'd4, 32'h0000_0000, 32'h0000_0001, '0);
      send_word(ptdt_pkg::CMD_SERVICE, 8'h00, '0, '0, '0);
   endtask

   // Random traffic in phases with different idling. Start times and periods
   // mostly sit close to the current time so that slots really fall due;
   // now and then any value goes, and so does any slot index.
   task automatic test_random_traffic(input int words);
      logic [ptdt_pkg::CMD_W-1:0]  cmd;
      logic [ptdt_pkg::SLOT_W-1:0] slot;
      logic [ptdt_pkg::TIME_W-1:0] start_time;
      logic [ptdt_pkg::TIME_W-1:0] period;
      logic [ptdt_pkg::TIME_W-1:0] new_time;
      int                          pick;
      for (int k = 0; k < words; k++) begin
         if (k % 70 == 0) begin
            case (k / 70)
               0:       begin req_idle = 1'b0; rsp_idle = 1'b0; end
               1:       begin req_idle = 1'b1; rsp_idle = 1'b1; end
               default: begin
                  req_idle = 1'($urandom_range(0, 1));
                  rsp_idle = 1'($urandom_range(0, 1));
               end
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            cmd = ptdt_pkg::CMD_TICK;
         end else if (pick < 50) begin
            cmd = ptdt_pkg::CMD_ADD;
         end else if (pick < 58) begin
            cmd = ptdt_pkg::CMD_RESTART;
         end else if (pick < 66) begin
            cmd = ptdt_pkg::CMD_PAUSE;
         end else if (pick < 82) begin
            cmd = ptdt_pkg::CMD_SERVICE;
         end else if (pick < 90) begin
            cmd = ptdt_pkg::CMD_SET_TIME;
         end else if (pick < 95) begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
         end else begin
            cmd = ptdt_pkg::CMD_W'($urandom_range(0, 7));
         end
         slot       = ($urandom_range(0, 9) == 0)
                      ? ptdt_pkg::SLOT_W'($urandom_range(0, 255))
                      : ptdt_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
         start_time = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : now_secs + $urandom_range(0, 6) - 3;
         period     = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5);
         new_time   = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : now_secs + $urandom_range(0, 4) - 2;
         send_word(cmd, slot, start_time, period, new_time);
      end
   endtask

   // Takes response words, after a random stall each if rsp_idle is set, and
   // compares every field with the oldest word still owed.
   initial begin : rsp_check
      int           stall;
      due_word_type want;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         words_checked++;
         if (rsp_bus.status == ptdt_pkg::STS_RUN) begin
            runs_reported++;
         end
         if (owed_words.size() == 0) begin
            $error("response word with none owed: status %0d, task_index %0d",
                   rsp_bus.status, rsp_bus.task_index);
            mismatches++;
         end else begin
            want = owed_words.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.task_index !== want.task_index) begin
               $error("task_index: expected %0d, got %0d", want.task_index,
                      rsp_bus.task_index);
               mismatches++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
               mismatches++;
            end
            if (rsp_bus.uptime !== want.uptime) begin
               $error("uptime: expected %0d, got %0d", want.uptime, rsp_bus.uptime);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, the directed cases, the random traffic, then the
   // drain and the verdict.
   initial begin : run_tests
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= ptdt_pkg::CMD_TICK;
      req_bus.slot       <= '0;
      req_bus.start_time <= '0;
      req_bus.period     <= '0;
      req_bus.new_time   <= '0;
      req_idle    = 1'b1;
      rsp_idle    = 1'b1;
      mismatches  = 0;
      words_sent  = 0;
      now_secs    = '0;
      uptime_secs = '0;
      foreach (slot_live[i]) begin
         slot_live[i]  = 1'b0;
         slot_owed[i]  = 1'b0;
         due_at[i]     = '0;
         repeat_gap[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_idle_table();
      test_bad_slot();
      test_full_table();
      test_random_traffic(420);
      req_bus.valid <= 1'b0;

      // Every word is answered, so once nothing is owed the block should be
      // idle; the extra cycles catch any stray response word.
      while (owed_words.size() != 0) @(posedge clock);
      repeat (2 * SLOTS + 8) @(posedge clock);

      $display("Sent %0d request words and checked %0d response words, %0d task reports.",
               words_sent, words_checked, runs_reported);
      $display("Ticks, adds, restarts, pauses, services, time loads, bad slots and %s",
               "spare codes ran under mixed idling.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // A hung handshake ends the run here; the bound is several times the
   // slowest correct run.
   initial begin : watchdog
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
